@@ rtl/core/mcrs_pkg.sv @@
// Shared types and constants for the missing-chunk range scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcrs_pkg;

	// Default chunk index width
	localparam int IDX_BITS_DEFAULT = 20;

	// Fixed field widths
	localparam int COUNT_BITS = 21;
	localparam int BYTE_BITS  = 31;
	localparam int RUN_BITS   = 13;
	localparam int CB_BITS    = 17;

	localparam logic [BYTE_BITS-1:0] BYTE_MAX = {BYTE_BITS{1'b1}};

	// Register defaults after reset
	localparam logic [RUN_BITS-1:0] MAX_RUN_RESET     = RUN_BITS'(1);
	localparam logic [CB_BITS-1:0]  CHUNK_BYTES_RESET = CB_BITS'(1024);

	// Configuration port
	localparam int CFG_ADDR_BITS = 3;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_TOTAL_CHUNKS    = 3'd0,
		REG_FILE_LAST_CHUNK = 3'd1,
		REG_SCAN_START      = 3'd2,
		REG_SCAN_END        = 3'd3,
		REG_MAX_RUN         = 3'd4,
		REG_CHUNK_BYTES     = 3'd5
	} reg_idx_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_RANGE   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// Result queue depth, power of two, at least 2
	localparam int FIFO_DEPTH = 4;

endpackage

@@ rtl/core/mcrs_result_fifo.sv @@
// Small result queue: up to two pushes per cycle, one pop per cycle.
// Depends on mcrs_pkg.
`timescale 1ns / 1ps

module mcrs_result_fifo import mcrs_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic             push1,     // only together with push0
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	output logic             room,      // at least two free slots
	output logic             dout_valid,
	input  logic             dout_ready,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [CNT_W-1:0] n_push;

	assign pop        = dout_valid && dout_ready;
	assign dout_valid = count_q != '0;
	assign dout       = mem_q[rd_ptr_q];
	assign room       = count_q <= CNT_W'(DEPTH - 2);
	assign n_push     = CNT_W'(push0) + CNT_W'(push1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0)
			mem_q[wr_ptr_q] <= din0;
		if (push1)
			mem_q[wr_ptr_q + PTR_W'(1)] <= din1;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overfilled");

	a_no_push_without_room: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> room)
		else $error("push into full result queue");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second push without first");

endmodule

@@ rtl/core/missing_chunk_range_scheduler.sv @@
// Top level of the missing-chunk range scheduler: config registers, scan tracker,
// result packing. Depends on mcrs_pkg and mcrs_result_fifo.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one request per chunk, in index order. tdata[0] is the
//   downloaded flag, tuser marks the first chunk of a scan (chunk scan_start).
//   Master stream: results. tuser is the kind (range, summary, start error),
//   tdata carries range_begin, range_end, range_count, byte_count; tlast
//   marks the summary or the error that closes a scan.
//   Config port: cfg_we/cfg_addr/cfg_wdata, one register per write; the user
//   must write only while the block is idle, which the block does not enforce.
// Timing
//   A request is registered in the input register, then decoded against the
//   tracker state; its results (zero, one or two) enter a 4-entry result queue.
//   The queue is registered and drives m_tvalid, so a result passes the input
//   register and the queue before it can be taken.
//   One request per cycle is taken as long as the queue has two free
//   slots; the queue drains one result per cycle, so the rate is one
//   request per cycle unless results pile up (two results per request
//   only when a run closes on the last chunk of a scan).
// Reset and stall
//   arst_n clears the tracker, the queue and the registers to their
//   defaults (max_run 1, chunk_bytes 1024, others 0). When the receiver
//   holds tready low the queue fills and s_tready drops; nothing is lost.

module missing_chunk_range_scheduler import mcrs_pkg::*; #(
	parameter int CHUNK_INDEX_BITS = IDX_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,

	// config write port
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [((CHUNK_INDEX_BITS + 1 > CB_BITS) ? CHUNK_INDEX_BITS + 1 : CB_BITS)-1:0]
		cfg_wdata,

	// chunk flags in
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] downloaded, rest zero
	input  logic       s_tuser,   // first_item

	// results out
	output logic m_tvalid,
	input  logic m_tready,
	// from bit 0: range_begin, range_end, range_count, byte_count, zero pad
	output logic [((2*CHUNK_INDEX_BITS + COUNT_BITS + BYTE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0] m_tuser,   // kind
	output logic       m_tlast
);

	localparam int IDX     = CHUNK_INDEX_BITS;
	localparam int PAY_W   = 2*IDX + COUNT_BITS + BYTE_BITS;
	localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;
	localparam int PROD_W  = (IDX + 1 + CB_BITS > BYTE_BITS + 1) ?
		IDX + 1 + CB_BITS : BYTE_BITS + 1;

	typedef struct packed {
		logic                  last;
		logic [BYTE_BITS-1:0]  bytes;
		logic [COUNT_BITS-1:0] cnt;
		logic [IDX-1:0]        r_end;
		logic [IDX-1:0]        r_begin;
		kind_t                 kind;
	} result_t;

	// ---------------- configuration registers ----------------
	logic [IDX:0]          total_chunks_q;
	logic [IDX-1:0]        file_last_chunk_q, scan_start_q, scan_end_q;
	logic [RUN_BITS-1:0]   max_run_q;
	logic [CB_BITS-1:0]    chunk_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_chunks_q    <= '0;
			file_last_chunk_q <= '0;
			scan_start_q      <= '0;
			scan_end_q        <= '0;
			max_run_q         <= MAX_RUN_RESET;
			chunk_bytes_q     <= CHUNK_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TOTAL_CHUNKS:    total_chunks_q    <= cfg_wdata[IDX:0];
				REG_FILE_LAST_CHUNK: file_last_chunk_q <= cfg_wdata[IDX-1:0];
				REG_SCAN_START:      scan_start_q      <= cfg_wdata[IDX-1:0];
				REG_SCAN_END:        scan_end_q        <= cfg_wdata[IDX-1:0];
				REG_MAX_RUN:         max_run_q         <= cfg_wdata[RUN_BITS-1:0];
				REG_CHUNK_BYTES:     chunk_bytes_q     <= cfg_wdata[CB_BITS-1:0];
				default: ;   // unused indexes are dropped
			endcase
		end
	end

	// ---------------- input register ----------------
	logic v_s1, first_s1, have_s1;
	logic fire, room;

	assign fire     = v_s1 && room;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1 <= s_tuser;
			have_s1  <= s_tdata[0];
		end
	end

	// ---------------- scan tracker state ----------------
	logic                  active_q, in_run_q;
	logic [IDX-1:0]        chunk_index_q, run_begin_q, last_range_end_q;
	logic [RUN_BITS-1:0]   run_length_q;
	logic [COUNT_BITS-1:0] ranges_q;

	logic                  active_n, in_run_n;
	logic [IDX-1:0]        idx_n, rb_n, lre_n;
	logic [RUN_BITS-1:0]   rl_n;
	logic [COUNT_BITS-1:0] cnt_n;

	// current view: a first item restarts from scan_start
	logic                  cur_in_run;
	logic [IDX-1:0]        cur_idx, cur_lre;
	logic [RUN_BITS-1:0]   cur_rl, limit;
	logic [COUNT_BITS-1:0] cur_cnt;

	logic           tc_zero, start_err, win_empty, at_end;
	logic [IDX:0]   tc_m1;
	logic [IDX-1:0] e_bound;

	// decode results
	logic           do_err, do_sum, rng_v;
	logic [IDX-1:0] rng_b, rng_e;

	assign tc_zero   = total_chunks_q == '0;
	assign tc_m1     = total_chunks_q - (IDX+1)'(1);
	assign start_err = scan_start_q > file_last_chunk_q;
	assign win_empty = tc_zero || ({1'b0, scan_start_q} > tc_m1) ||
		(scan_start_q > scan_end_q);
	// scan end: min(scan_end, total_chunks-1)
	assign e_bound   = tc_zero ? '0 :
		(({1'b0, scan_end_q} > tc_m1) ? tc_m1[IDX-1:0] : scan_end_q);

	assign cur_in_run = first_s1 ? 1'b0 : in_run_q;
	assign cur_idx    = first_s1 ? scan_start_q : chunk_index_q;
	assign cur_lre    = first_s1 ? scan_start_q : last_range_end_q;
	assign cur_rl     = first_s1 ? '0 : run_length_q;
	assign cur_cnt    = first_s1 ? '0 : ranges_q;
	assign limit      = (max_run_q == '0) ? RUN_BITS'(1) : max_run_q;
	assign at_end     = cur_idx >= e_bound;

	always_comb begin
		active_n = active_q;
		in_run_n = cur_in_run;
		idx_n    = cur_idx;
		rb_n     = run_begin_q;
		rl_n     = cur_rl;
		lre_n    = cur_lre;
		cnt_n    = cur_cnt;
		do_err   = 1'b0;
		do_sum   = 1'b0;
		rng_v    = 1'b0;
		rng_b    = '0;
		rng_e    = '0;

		priority if (first_s1 && start_err) begin
			do_err   = 1'b1;
			active_n = 1'b0;
		end else if (first_s1 && win_empty) begin
			do_sum   = 1'b1;
			active_n = 1'b0;
		end else if (first_s1 || active_q) begin
			if (have_s1) begin
				// downloaded chunk closes an open run just before it
				if (cur_in_run) begin
					rng_v    = 1'b1;
					rng_b    = run_begin_q;
					rng_e    = cur_idx - IDX'(1);
					in_run_n = 1'b0;
				end
			end else begin
				if (!cur_in_run) begin
					rb_n = cur_idx;
					rl_n = RUN_BITS'(1);
				end else begin
					rl_n = cur_rl + RUN_BITS'(1);
				end
				in_run_n = 1'b1;
				if (rl_n >= limit || at_end) begin
					rng_v    = 1'b1;
					rng_b    = rb_n;
					rng_e    = cur_idx;
					in_run_n = 1'b0;
				end
			end
			if (rng_v) begin
				lre_n = rng_e;
				cnt_n = cur_cnt + COUNT_BITS'(1);
			end
			if (at_end) begin
				do_sum   = 1'b1;
				active_n = 1'b0;
				in_run_n = 1'b0;
			end else begin
				idx_n    = cur_idx + IDX'(1);
				active_n = 1'b1;
			end
		end else begin
			// request outside a scan: dropped, state held
		end
	end

	// byte count: (last range end - scan_start + 1) * chunk_bytes, saturated
	logic [IDX:0]           span;
	logic [PROD_W-1:0]      prod;
	logic [BYTE_BITS-1:0]   bytes;

	assign span  = {1'b0, lre_n - scan_start_q} + (IDX+1)'(1);
	assign prod  = PROD_W'(span) * PROD_W'(chunk_bytes_q);
	assign bytes = (prod > PROD_W'(BYTE_MAX)) ? BYTE_MAX : prod[BYTE_BITS-1:0];

	// ---------------- result assembly ----------------
	result_t res_rng, res_sum, res_err, res0, res1;
	logic    push0, push1;

	always_comb begin
		res_rng         = '0;
		res_rng.kind    = KIND_RANGE;
		res_rng.r_begin = rng_b;
		res_rng.r_end   = rng_e;

		res_sum       = '0;
		res_sum.kind  = KIND_SUMMARY;
		res_sum.cnt   = cnt_n;
		res_sum.bytes = bytes;
		res_sum.last  = 1'b1;

		res_err      = '0;
		res_err.kind = KIND_ERROR;
		res_err.last = 1'b1;

		// range first, then the summary that may follow it
		res1  = res_sum;
		push1 = fire && rng_v && do_sum;
		push0 = fire && (rng_v || do_sum || do_err);
		priority if (do_err)
			res0 = res_err;
		else if (rng_v)
			res0 = res_rng;
		else
			res0 = res_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			in_run_q         <= 1'b0;
			chunk_index_q    <= '0;
			run_begin_q      <= '0;
			run_length_q     <= '0;
			last_range_end_q <= '0;
			ranges_q         <= '0;
		end else if (fire) begin
			active_q         <= active_n;
			in_run_q         <= in_run_n;
			chunk_index_q    <= idx_n;
			run_begin_q      <= rb_n;
			run_length_q     <= rl_n;
			last_range_end_q <= lre_n;
			ranges_q         <= cnt_n;
		end
	end

	// ---------------- output queue ----------------
	logic [$bits(result_t)-1:0] q_dout;
	result_t                    head;

	mcrs_result_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push0      (push0),
		.push1      (push1),
		.din0       (res0),
		.din1       (res1),
		.room       (room),
		.dout_valid (m_tvalid),
		.dout_ready (m_tready),
		.dout       (q_dout)
	);

	assign head    = result_t'(q_dout);
	assign m_tdata = TDATA_W'({head.bytes, head.cnt, head.r_end, head.r_begin});
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// ---------------- checks ----------------
	a_run_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> active_q)
		else $error("open run outside an active scan");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(push0 && (res0.last || push1)) |=> !active_q)
		else $error("scan still active after its closing result");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(push0 && res0.kind == KIND_RANGE) |-> res0.r_begin <= res0.r_end)
		else $error("range begin past range end");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !first_s1 && !active_q) |-> !push0)
		else $error("result from a request outside any scan");

endmodule

@@ verif/tb_missing_chunk_range_scheduler.sv @@
// Self-checking testbench for missing_chunk_range_scheduler: directed table plus random scans,
// every result checked against an in-bench range tracker or a typed expectation. Depends on mcrs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_missing_chunk_range_scheduler;
	import mcrs_pkg::*;

	localparam int IDX_BITS     = IDX_BITS_DEFAULT;
	localparam int WDATA_BITS   = (IDX_BITS + 1 > CB_BITS) ? IDX_BITS + 1 : CB_BITS;
	localparam int MDATA_BITS   = ((2*IDX_BITS + COUNT_BITS + BYTE_BITS + 7) / 8) * 8;
	localparam int DRAIN_CYCLES = 8;     // margin for requests with no result
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the result queue
	localparam int STALL_LIMIT  = 3000;  // cycles with no handshake before giving up
	localparam int PHASE_ITEMS  = 140;

	// one expected result, fields at block widths
	typedef struct packed {
		kind_t                 kind;
		logic [IDX_BITS-1:0]   first_chunk;
		logic [IDX_BITS-1:0]   stop_chunk;
		logic [COUNT_BITS-1:0] count;
		logic [BYTE_BITS-1:0]  bytes;
		logic                  closes_scan;
	} range_result_t;

	// directed table row: either a register write or one chunk request
	typedef struct {
		bit              is_cfg;
		reg_idx_t        idx;
		logic [WDATA_BITS-1:0] val;
		bit              first;
		bit              have;
		bit              typed;   // expected result typed in below, not predicted
		range_result_t   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [WDATA_BITS-1:0]    cfg_wdata;

	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [0] downloaded, [7:1] zero
	logic       s_tuser;   // first_item

	logic                  m_tvalid;
	logic                  m_tready;
	logic [MDATA_BITS-1:0] m_tdata;   // from bit 0: range_begin, range_end, range_count, byte_count
	logic [1:0]            m_tuser;   // kind
	logic                  m_tlast;

	missing_chunk_range_scheduler #(
		.CHUNK_INDEX_BITS(IDX_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// ---------------------------------------------------------------
	// Register shadow, as written through the config port
	// ---------------------------------------------------------------
	logic [COUNT_BITS-1:0] r_total   = '0;
	logic [IDX_BITS-1:0]   r_flc     = '0;
	logic [IDX_BITS-1:0]   r_ss      = '0;
	logic [IDX_BITS-1:0]   r_se      = '0;
	logic [RUN_BITS-1:0]   r_max_run = MAX_RUN_RESET;
	logic [CB_BITS-1:0]    r_cb      = CHUNK_BYTES_RESET;

	// Tracker state of the predictor
	bit                    p_active  = 1'b0;
	bit                    p_in_run  = 1'b0;
	logic [IDX_BITS-1:0]   p_ci      = '0;
	logic [IDX_BITS-1:0]   p_run_begin = '0;
	logic [RUN_BITS-1:0]   p_run_len = '0;
	logic [IDX_BITS-1:0]   p_last_end = '0;
	logic [COUNT_BITS-1:0] p_ranges  = '0;

	range_result_t step_out[$];          // results of the request just accepted
	range_result_t scan_results_due[$];  // results still to come out of the block
	stim_row_t     stim_table[$];

	int  mismatches    = 0;
	int  items_done    = 0;   // requests the block acts on (not the ignored ones)
	int  send_idle_pct = 18;
	int  recv_idle_pct = 48;
	bit  hold_req      = 1'b0;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic void note_result(kind_t k, logic [IDX_BITS-1:0] b, logic [IDX_BITS-1:0] e,
			logic [COUNT_BITS-1:0] c, logic [BYTE_BITS-1:0] y, bit l);
		step_out.push_back('{k, b, e, c, y, l});
	endfunction

	function automatic void add_range(logic [IDX_BITS-1:0] b, logic [IDX_BITS-1:0] e);
		note_result(KIND_RANGE, b, e, '0, '0, 1'b0);
		p_last_end = e;
		p_ranges   = p_ranges + 1'b1;
	endfunction

	// byte count spans scan start to last range end, modulo the index width
	function automatic void close_scan();
		logic [IDX_BITS-1:0] diff;
		longint unsigned     span;
		longint unsigned     total_bytes;
		diff        = p_last_end - r_ss;
		span        = longint'(diff) + 1;
		total_bytes = span * r_cb;
		if (total_bytes > BYTE_MAX)
			total_bytes = BYTE_MAX;
		note_result(KIND_SUMMARY, '0, '0, p_ranges, total_bytes[BYTE_BITS-1:0], 1'b1);
		p_active = 1'b0;
		p_in_run = 1'b0;
	endfunction

	function automatic void track_chunk(bit first, bit have);
		int unsigned limit;
		int unsigned e_bound;
		step_out.delete();
		if (first || p_active)
			items_done++;
		limit = (r_max_run == 0) ? 1 : r_max_run;
		if (first) begin
			p_active   = 1'b0;
			p_in_run   = 1'b0;
			p_run_len  = '0;
			p_ranges   = '0;
			p_last_end = r_ss;
			p_ci       = r_ss;
			if (r_ss > r_flc) begin
				note_result(KIND_ERROR, '0, '0, '0, '0, 1'b1);
				return;
			end
			// empty window: summary straight away
			if (r_total == 0 || r_ss > r_total - 1 || r_ss > r_se) begin
				close_scan();
				return;
			end
			p_active = 1'b1;
		end else if (!p_active) begin
			return;
		end

		e_bound = r_se;
		if (r_total == 0)
			e_bound = 0;
		else if (r_total - 1 < e_bound)
			e_bound = r_total - 1;

		if (have) begin
			if (p_in_run) begin
				add_range(p_run_begin, p_ci - 1'b1);
				p_in_run = 1'b0;
			end
		end else begin
			if (!p_in_run) begin
				p_in_run    = 1'b1;
				p_run_begin = p_ci;
				p_run_len   = '0;
			end
			p_run_len = p_run_len + 1'b1;
			if (p_run_len >= limit || p_ci >= e_bound) begin
				add_range(p_run_begin, p_ci);
				p_in_run = 1'b0;
			end
		end

		if (p_ci >= e_bound)
			close_scan();
		else
			p_ci = p_ci + 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Directed table builders
	// ---------------------------------------------------------------
	function automatic void add_cfg(reg_idx_t idx, int unsigned val);
		stim_table.push_back('{1'b1, idx, val[WDATA_BITS-1:0], 1'b0, 1'b0, 1'b0, '0});
	endfunction

	function automatic void add_chunk(bit first, bit have);
		stim_table.push_back('{1'b0, REG_TOTAL_CHUNKS, '0, first, have, 1'b0, '0});
	endfunction

	function automatic void add_checked(bit first, bit have, range_result_t want);
		stim_table.push_back('{1'b0, REG_TOTAL_CHUNKS, '0, first, have, 1'b1, want});
	endfunction

	// ---------------------------------------------------------------
	// Drivers: inputs move on the falling edge, handshakes seen on the rising one
	// ---------------------------------------------------------------
	task automatic send_item(input bit first, input bit have, input bit typed,
			input range_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= first;
		s_tdata  <= {7'd0, have};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_chunk(first, have);
		if (typed)
			scan_results_due.push_back(want);
		else
			foreach (step_out[i])
				scan_results_due.push_back(step_out[i]);
	endtask

	// stop offering, let every expected result out, then cover the pipeline
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (scan_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input int unsigned val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val[WDATA_BITS-1:0];
		@(posedge clk);
		case (idx)
			REG_TOTAL_CHUNKS: begin
				r_total = val[COUNT_BITS-1:0];
			end
			REG_FILE_LAST_CHUNK: begin
				r_flc = val[IDX_BITS-1:0];
			end
			REG_SCAN_START: begin
				r_ss = val[IDX_BITS-1:0];
			end
			REG_SCAN_END: begin
				r_se = val[IDX_BITS-1:0];
			end
			REG_MAX_RUN: begin
				r_max_run = val[RUN_BITS-1:0];
			end
			REG_CHUNK_BYTES: begin
				r_cb = val[CB_BITS-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input int unsigned total, input int unsigned flc,
			input int unsigned ss, input int unsigned se, input int unsigned mr,
			input int unsigned cb);
		wait_drain();
		cfg_write(REG_TOTAL_CHUNKS, total);
		cfg_write(REG_FILE_LAST_CHUNK, flc);
		cfg_write(REG_SCAN_START, ss);
		cfg_write(REG_SCAN_END, se);
		cfg_write(REG_MAX_RUN, mr);
		cfg_write(REG_CHUNK_BYTES, cb);
	endtask

	// mostly short windows near 0, some at the top of the index space
	task automatic randomize_config();
		int unsigned total, flc, ss, se, mr, cb, pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			total = $urandom_range(1048576, 1048530);
			ss    = $urandom_range(1048575, 1048520);
			se    = $urandom_range(1048575, 1048500);
			flc   = ($urandom_range(99) < 85) ? 1048575 : $urandom_range(1048575, 0);
		end else begin
			total = $urandom_range(60, 0);
			ss    = $urandom_range(63, 0);
			se    = $urandom_range(70, 0);
			flc   = ($urandom_range(99) < 85) ? $urandom_range(63, ss) : $urandom_range(63, 0);
		end
		pick = $urandom_range(99);
		mr = (pick < 60) ? $urandom_range(5, 0) :
			(pick < 90) ? $urandom_range(40, 6) : $urandom_range(4096, 41);
		pick = $urandom_range(99);
		cb = (pick < 50) ? $urandom_range(65536, 1) :
			(pick < 75) ? $urandom_range(16, 1) : $urandom_range(65536, 65535);
		load_config(total, flc, ss, se, mr, cb);
	endtask

	// one scan: first request then flags until the summary; a few restarts,
	// abandoned scans and stray requests mixed in
	task automatic random_scan();
		int unsigned have_pct, r;
		if ($urandom_range(99) < 30)
			randomize_config();
		if ($urandom_range(99) < 8)
			send_item(1'b0, 1'($urandom_range(1)), 1'b0, '0);
		have_pct = $urandom_range(100, 0);
		send_item(1'b1, $urandom_range(99) < have_pct, 1'b0, '0);
		while (p_active) begin
			r = $urandom_range(99);
			if (r < 3)
				break;
			send_item(r < 7, $urandom_range(99) < have_pct, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Receiver: random backpressure, one long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// Result checker: each result against the oldest expectation
	// ---------------------------------------------------------------
	range_result_t seen_want;

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (scan_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none actual kind %0d tdata %h",
					$time, m_tuser, m_tdata);
			end else begin
				seen_want = scan_results_due.pop_front();
				check_field("kind", seen_want.kind, m_tuser);
				check_field("range_begin", seen_want.first_chunk, m_tdata[IDX_BITS-1:0]);
				check_field("range_end", seen_want.stop_chunk, m_tdata[2*IDX_BITS-1:IDX_BITS]);
				check_field("range_count", seen_want.count,
					m_tdata[2*IDX_BITS+COUNT_BITS-1:2*IDX_BITS]);
				check_field("byte_count", seen_want.bytes,
					m_tdata[2*IDX_BITS+COUNT_BITS+BYTE_BITS-1:2*IDX_BITS+COUNT_BITS]);
				check_field("last", seen_want.closes_scan, m_tlast);
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: too long without any handshake or register write
	// ---------------------------------------------------------------
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stall = 0;
			else
				stall++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_TOTAL_CHUNKS;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;

		// right after reset: total 0 -> empty window, one chunk of 1024 bytes
		add_checked(1'b1, 1'b0, '{KIND_SUMMARY, 20'd0, 20'd0, 21'd0, 31'd1024, 1'b1});
		add_chunk(1'b0, 1'b0);   // outside a scan, ignored

		// window 2..9, max run 3: max-run close, downloaded close, close at scan end
		add_cfg(REG_TOTAL_CHUNKS, 16);
		add_cfg(REG_FILE_LAST_CHUNK, 15);
		add_cfg(REG_SCAN_START, 2);
		add_cfg(REG_SCAN_END, 9);
		add_cfg(REG_MAX_RUN, 3);
		add_cfg(REG_CHUNK_BYTES, 100);
		add_chunk(1'b1, 1'b1);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b1);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b1);
		add_chunk(1'b0, 1'b0);   // last chunk: range plus summary
		add_chunk(1'b0, 1'b0);   // after the scan, ignored

		// restart mid-scan drops the open run silently
		add_cfg(REG_SCAN_END, 4);
		add_chunk(1'b1, 1'b0);
		add_chunk(1'b1, 1'b1);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);

		// start beyond the allowed chunk: error, then ignored until next first
		add_cfg(REG_SCAN_START, 20);
		add_checked(1'b1, 1'b0, '{KIND_ERROR, 20'd0, 20'd0, 21'd0, 31'd0, 1'b1});
		add_chunk(1'b0, 1'b0);

		// start past the window end: summary at once
		add_cfg(REG_SCAN_START, 10);
		add_checked(1'b1, 1'b1, '{KIND_SUMMARY, 20'd0, 20'd0, 21'd0, 31'd100, 1'b1});

		// top of the index space, max run zero acts as one, largest chunk size
		add_cfg(REG_TOTAL_CHUNKS, 1048576);
		add_cfg(REG_FILE_LAST_CHUNK, 1048575);
		add_cfg(REG_SCAN_START, 1048575);
		add_cfg(REG_SCAN_END, 1048575);
		add_cfg(REG_MAX_RUN, 0);
		add_cfg(REG_CHUNK_BYTES, 65536);
		add_chunk(1'b1, 1'b0);

		// scan start moved mid-scan: span covers the whole index space, byte count saturates
		add_cfg(REG_SCAN_START, 1048570);
		add_cfg(REG_MAX_RUN, 4096);
		add_chunk(1'b1, 1'b0);
		add_chunk(1'b0, 1'b0);
		add_cfg(REG_SCAN_START, 0);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);
		add_chunk(1'b0, 1'b0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				wait_drain();
				cfg_write(stim_table[i].idx, stim_table[i].val);
			end else begin
				send_item(stim_table[i].first, stim_table[i].have, stim_table[i].typed,
					stim_table[i].want);
			end
		end

		// every chunk missing with max run 1: one range per request while
		// the receiver holds off, so the queue fills and s_tready drops
		load_config(64, 63, 0, 63, 1, 512);
		hold_req = 1'b1;
		send_item(1'b1, 1'b0, 1'b0, '0);
		while (p_active)
			send_item(1'b0, 1'b0, 1'b0, '0);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// leftover registers may describe a huge window; start fresh
			randomize_config();
			begin
				int target;
				target = items_done + PHASE_ITEMS;
				while (items_done < target)
					random_scan();
			end
		end

		wait_drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ missing_chunk_range_scheduler.f @@
rtl/core/mcrs_pkg.sv
rtl/core/mcrs_result_fifo.sv
rtl/core/missing_chunk_range_scheduler.sv
verif/tb_missing_chunk_range_scheduler.sv
